### rtl/npcm_pkg.sv
// shared types and constants for the nearest palette color match block
package npcm_pkg;

   localparam int DefaultPaletteSize = 256;
   localparam int ChanW = 8;
   localparam int IndexW = 8;
   localparam int ColorW = 16;
   // three squared 8-bit differences need 18 bits
   localparam int ErrW = 18;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef struct packed {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic shift;
      logic write;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_REPLY
   } state_type;

   // widen a 5-6-5 color to 8-8-8 with zero low bits
   function automatic rgb_type widen_565(input logic [ColorW-1:0] color);
      rgb_type c;
      c.red   = {color[15:11], 3'b000};
      c.green = {color[10:5], 2'b00};
      c.blue  = {color[4:0], 3'b000};
      return c;
   endfunction

endpackage

### rtl/npcm_cell.sv
// one palette entry of the rotating ring
module npcm_cell
   import npcm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  rgb_type       wr_data,
   input  rgb_type       nbr_entry,
   output rgb_type       entry
);

   rgb_type entry_ff;
   rgb_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.write) begin
         entry_in = wr_data;
      end else if (ctrl.shift) begin
         entry_in = nbr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

### rtl/npcm_dist.sv
// squared rgb distance between the query and the entry at the head of the ring
module npcm_dist
   import npcm_pkg::*;
#(
   parameter int PALETTE_SIZE = DefaultPaletteSize,
   localparam int IdxW = $clog2(PALETTE_SIZE)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [IdxW-1:0] in_idx,
   input  rgb_type         query,
   input  rgb_type         entry,
   output logic            out_valid,
   output logic [IdxW-1:0] out_idx,
   output logic [ErrW-1:0] out_err
);

   logic [ChanW-1:0]   dr, dg, db;
   logic [2*ChanW-1:0] sr, sg, sb;
   logic [ErrW-1:0]    err_in;
   logic [ErrW-1:0]    err_ff;
   logic [IdxW-1:0]    idx_ff;
   logic               valid_ff;

   always_comb begin
      dr = (entry.red >= query.red) ? entry.red - query.red : query.red - entry.red;
      dg = (entry.green >= query.green) ? entry.green - query.green
                                        : query.green - entry.green;
      db = (entry.blue >= query.blue) ? entry.blue - query.blue : query.blue - entry.blue;
      sr = (2*ChanW)'(dr) * (2*ChanW)'(dr);
      sg = (2*ChanW)'(dg) * (2*ChanW)'(dg);
      sb = (2*ChanW)'(db) * (2*ChanW)'(db);
      err_in = ErrW'(sr) + ErrW'(sg) + ErrW'(sb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      err_ff <= err_in;
      idx_ff <= in_idx;
   end

   assign out_valid = valid_ff;
   assign out_idx   = idx_ff;
   assign out_err   = err_ff;

endmodule

### rtl/nearest_palette_color_match.sv
// top level: palette ring, distance stage and running minimum
// Nearest palette color match.
// A beat is taken on start while busy is low. With req_operation at write,
// the entry fields land in palette slot req_entry_index in that same edge;
// slots at or beyond the palette size are ignored, busy stays low and no
// result follows, so writes may come every cycle.
// With req_operation at lookup, req_query_color (5-6-5) is captured and
// busy rises. The palette sits in a ring of cells that rotates one slot a
// cycle past a single distance unit: the scan state covers every slot, then
// the drain state waits for the registered distance of the last slot, then
// the reply state raises rsp_valid for one cycle. busy stays high through
// the strobe cycle and falls at the end of it, so no new beat is taken while
// a lookup is under way. rsp_best_index holds the nearest slot, lowest slot
// on ties, while rsp_valid is high; the receiver cannot stall.
// Reset clears every slot to black and returns the block to idle.
module nearest_palette_color_match
   import npcm_pkg::*;
#(
   parameter int PALETTE_SIZE = DefaultPaletteSize
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_operation,
   input  logic [IndexW-1:0] req_entry_index,
   input  logic [ChanW-1:0]  req_entry_red,
   input  logic [ChanW-1:0]  req_entry_green,
   input  logic [ChanW-1:0]  req_entry_blue,
   input  logic [ColorW-1:0] req_query_color,
   output logic              rsp_valid,
   output logic [IndexW-1:0] rsp_best_index
);

   localparam int IdxW = $clog2(PALETTE_SIZE);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(PALETTE_SIZE - 1);

   state_type       state_ff, state_in;
   logic [IdxW-1:0] cnt_ff, cnt_in;
   rgb_type         query_ff, query_in;
   logic [ErrW-1:0] best_err_ff, best_err_in;
   logic [IdxW-1:0] best_idx_ff, best_idx_in;

   logic            accept;
   logic            wr_beat;
   logic            scanning;
   rgb_type         wr_data;
   rgb_type         ring [PALETTE_SIZE];

   logic            dist_valid;
   logic [IdxW-1:0] dist_idx;
   logic [ErrW-1:0] dist_err;

   assign accept   = start && !busy;
   assign wr_beat  = accept && (req_operation == OP_WRITE);
   assign scanning = (state_ff == ST_SCAN);
   assign wr_data  = '{red: req_entry_red, green: req_entry_green, blue: req_entry_blue};

   for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
      localparam int Nbr = (i + 1) % PALETTE_SIZE;
      cell_ctrl_type ctrl;
      // slots at 256 and above cannot be addressed and stay black
      if (i < 256) begin : g_wr
         assign ctrl.write = wr_beat && (req_entry_index == IndexW'(i));
      end else begin : g_ro
         assign ctrl.write = 1'b0;
      end
      assign ctrl.shift = scanning;

      npcm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .wr_data   (wr_data),
         .nbr_entry (ring[Nbr]),
         .entry     (ring[i])
      );
   end

   npcm_dist #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scanning),
      .in_idx    (cnt_ff),
      .query     (query_ff),
      .entry     (ring[0]),
      .out_valid (dist_valid),
      .out_idx   (dist_idx),
      .out_err   (dist_err)
   );

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      query_in    = query_ff;
      best_err_in = best_err_ff;
      best_idx_in = best_idx_ff;

      // first entry seeds the minimum, later ones replace it only when strictly closer
      if (dist_valid && ((dist_idx == '0) || (dist_err < best_err_ff))) begin
         best_err_in = dist_err;
         best_idx_in = dist_idx;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_operation == OP_LOOKUP)) begin
               query_in = widen_565(req_query_color);
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + IdxW'(1);
            if (cnt_ff == LastIdx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff    <= query_in;
      best_err_ff <= best_err_in;
      best_idx_ff <= best_idx_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_REPLY);
   assign rsp_best_index = IndexW'(best_idx_ff);

`ifndef SYNTHESIS
   a_rsp_after_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DRAIN))
      else $error("result strobe without a finished scan");

   a_lookup_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_operation == OP_LOOKUP)) |=> (busy && cnt_ff == '0))
      else $error("lookup beat did not start a scan");

   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_operation == OP_WRITE)) |=> !busy)
      else $error("palette write left the block busy");

   a_dist_in_scan: assert property (@(posedge clock) disable iff (reset)
      dist_valid |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("distance beat outside a scan");
`endif

endmodule

### tb/sv/tb_nearest_palette_color_match.sv
// testbench for the nearest palette color match block: palette writes and nearest-entry lookups
module tb_nearest_palette_color_match;
   import npcm_pkg::*;

   localparam int PaletteSize = DefaultPaletteSize;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_operation;
   logic [IndexW-1:0] req_entry_index;
   logic [ChanW-1:0]  req_entry_red;
   logic [ChanW-1:0]  req_entry_green;
   logic [ChanW-1:0]  req_entry_blue;
   logic [ColorW-1:0] req_query_color;
   logic              rsp_valid;
   logic [IndexW-1:0] rsp_best_index;

   rgb_type           shadow_palette [PaletteSize];
   logic [IndexW-1:0] index_queue [$];
   int                fail_count = 0;
   int                burst_left = 0;

   nearest_palette_color_match #(
      .PALETTE_SIZE(PaletteSize)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_entry_index(req_entry_index),
      .req_entry_red(req_entry_red),
      .req_entry_green(req_entry_green),
      .req_entry_blue(req_entry_blue),
      .req_query_color(req_query_color),
      .rsp_valid(rsp_valid),
      .rsp_best_index(rsp_best_index)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scan the shadow palette for the least squared distance, first slot wins ties
   function automatic logic [IndexW-1:0] nearest_slot(input logic [ColorW-1:0] color);
      int qr, qg, qb, dr, dg, db, sum_sq, best_dist, best;
      qr = int'({color[15:11], 3'b000});
      qg = int'({color[10:5], 2'b00});
      qb = int'({color[4:0], 3'b000});
      best = 0;
      best_dist = -1;
      for (int s = 0; s < PaletteSize; s++) begin
         dr = int'(shadow_palette[s].red) - qr;
         dg = int'(shadow_palette[s].green) - qg;
         db = int'(shadow_palette[s].blue) - qb;
         sum_sq = dr * dr + dg * dg + db * db;
         if (best_dist < 0 || sum_sq < best_dist) begin
            best = s;
            best_dist = sum_sq;
         end
      end
      // slots past 255 wrap to the low index bits
      return best[IndexW-1:0];
   endfunction

   function automatic logic [ColorW-1:0] pack_565(input rgb_type rgb);
      return {rgb.red[7:3], rgb.green[7:2], rgb.blue[7:3]};
   endfunction

   function automatic rgb_type random_rgb();
      rgb_type rgb;
      rgb.red   = 8'($urandom_range(0, 255));
      rgb.green = 8'($urandom_range(0, 255));
      rgb.blue  = 8'($urandom_range(0, 255));
      return rgb;
   endfunction

   // predictor and checker share one process so a beat and a result never race
   always @(posedge clock) begin
      logic [IndexW-1:0] want;
      if (reset) begin
         foreach (shadow_palette[i]) shadow_palette[i] = '0;
      end else begin
         if (rsp_valid) begin
            if (index_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result beat: best_index %0d", rsp_best_index);
            end else begin
               want = index_queue.pop_front();
               if (rsp_best_index !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("best_index mismatch: expected %0d, actual %0d",
                              want, rsp_best_index);
               end
            end
         end
         if (start && !busy) begin
            if (req_operation == OP_WRITE) begin
               if (req_entry_index < PaletteSize) begin
                  shadow_palette[req_entry_index].red   = req_entry_red;
                  shadow_palette[req_entry_index].green = req_entry_green;
                  shadow_palette[req_entry_index].blue  = req_entry_blue;
               end
            end else begin
               index_queue.push_back(nearest_slot(req_query_color));
            end
         end
      end
   end

   // drive one beat and hold it until the block takes it; bursts with random gaps
   task automatic send_beat(input logic op, input logic [IndexW-1:0] idx,
                            input rgb_type rgb, input logic [ColorW-1:0] color);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 7))
            0, 1:    gap = 0;
            2:       gap = $urandom_range(1, 300);
            default: gap = $urandom_range(1, 20);
         endcase
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      start           <= 1'b1;
      req_operation   <= op;
      req_entry_index <= idx;
      req_entry_red   <= rgb.red;
      req_entry_green <= rgb.green;
      req_entry_blue  <= rgb.blue;
      req_query_color <= color;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // unused fields always carry random values
   task automatic write_slot(input logic [IndexW-1:0] idx, input rgb_type rgb);
      send_beat(OP_WRITE, idx, rgb, 16'($urandom_range(0, 65535)));
   endtask

   task automatic look_up(input logic [ColorW-1:0] color);
      send_beat(OP_LOOKUP, 8'($urandom_range(0, 255)), random_rgb(), color);
   endtask

   task automatic test_black_palette();
      // every slot black: all distances tie, slot 0 wins
      look_up(16'h0000);
      look_up(16'hffff);
      look_up(16'h8410);
   endtask

   task automatic test_extremes();
      write_slot(8'd255, '{red: 8'hff, green: 8'hff, blue: 8'hff});
      look_up(16'hffff);
      write_slot(8'd128, '{red: 8'hf8, green: 8'hfc, blue: 8'hf8});
      look_up(16'hffff);
      write_slot(8'd1, '{red: 8'hff, green: 8'h00, blue: 8'h00});
      write_slot(8'd2, '{red: 8'h00, green: 8'hff, blue: 8'h00});
      write_slot(8'd3, '{red: 8'h00, green: 8'h00, blue: 8'hff});
      look_up(16'hf800);
      look_up(16'h07e0);
      look_up(16'h001f);
      write_slot(8'd0, '{red: 8'h55, green: 8'haa, blue: 8'h55});
      look_up(16'h0000);
   endtask

   task automatic test_ties();
      rgb_type tie_rgb;
      tie_rgb = '{red: 8'h40, green: 8'h80, blue: 8'hc0};
      write_slot(8'd200, tie_rgb);
      write_slot(8'd7, tie_rgb);
      look_up(pack_565(tie_rgb));
      write_slot(8'd5, tie_rgb);
      look_up(pack_565(tie_rgb));
      // two different colors at equal distance from the query, though black slots such as 4 lie closer
      write_slot(8'd10, '{red: 8'h10, green: 8'h00, blue: 8'h00});
      write_slot(8'd9, '{red: 8'h00, green: 8'h00, blue: 8'h10});
      look_up(16'h0000);
   endtask

   task automatic test_random_mix(input int count);
      rgb_type           rgb;
      logic [ColorW-1:0] color;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 60) begin
            case ($urandom_range(0, 4))
               0: rgb = shadow_palette[$urandom_range(0, PaletteSize - 1)];
               1: begin
                  rgb.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
                  rgb.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
                  rgb.blue  = $urandom_range(0, 1) ? 8'hff : 8'h00;
               end
               2: begin
                  // on the 5-6-5 grid so exact hits occur
                  rgb = random_rgb();
                  rgb.red[2:0]   = 3'b000;
                  rgb.green[1:0] = 2'b00;
                  rgb.blue[2:0]  = 3'b000;
               end
               default: rgb = random_rgb();
            endcase
            write_slot(8'($urandom_range(0, 255)), rgb);
         end else begin
            if ($urandom_range(0, 1)) begin
               color = pack_565(shadow_palette[$urandom_range(0, PaletteSize - 1)]);
               if ($urandom_range(0, 1))
                  color = color ^ (16'(1) << $urandom_range(0, 15));
            end else begin
               color = 16'($urandom_range(0, 65535));
            end
            look_up(color);
         end
      end
   endtask

   task automatic test_pause_drain();
      start <= 1'b0;
      while (index_queue.size() != 0) @(posedge clock);
      repeat ($urandom_range(1, 10)) @(posedge clock);
      look_up(16'($urandom_range(0, 65535)));
   endtask

   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_operation   <= OP_WRITE;
      req_entry_index <= '0;
      req_entry_red   <= '0;
      req_entry_green <= '0;
      req_entry_blue  <= '0;
      req_query_color <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_black_palette();
      test_extremes();
      test_ties();
      test_random_mix(750);
      test_pause_drain();
      test_random_mix(780);

      start <= 1'b0;
      while (index_queue.size() != 0) @(posedge clock);
      repeat (PaletteSize + 8) @(posedge clock);
      if (fail_count == 0 && index_queue.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
